// ===== rtl/gapbm_pkg.sv =====
// Shared types and constants for the gate-array port and bank mapper.
// Holds the access kinds, port function codes, result word layout and bank table.
// No dependencies.
`default_nettype none

package gapbm_pkg;

    // Access kinds carried in s_tuser
    localparam logic [1:0] KIND_PORT_WR = 2'd0;
    localparam logic [1:0] KIND_MEM_RD  = 2'd1;
    localparam logic [1:0] KIND_MEM_WR  = 2'd2;

    // Function codes in data bits 7-6 of a port write
    localparam logic [1:0] FUNC_PEN_SEL  = 2'd0;
    localparam logic [1:0] FUNC_PEN_COL  = 2'd1;
    localparam logic [1:0] FUNC_MODE_ROM = 2'd2;
    localparam logic [1:0] FUNC_RAM_CFG  = 2'd3;

    // Pens 0..PEN_COUNT-1 are palette entries; higher selections address the border
    localparam int unsigned PEN_COUNT = 16;
    localparam int unsigned PEN_W     = 5;

    localparam logic [1:0] QTR_LOWER = 2'd0;
    localparam logic [1:0] QTR_UPPER = 2'd3;

    typedef struct packed {
        logic [4:0]  border_color;
        logic [1:0]  screen_mode;
        logic [7:0]  write_data;
        logic        write_enable;
        logic [13:0] offset;
        logic [2:0]  ram_block;
        logic        rom_choice;
        logic        to_rom;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    // Physical 16K block for a bank table and an address quarter
    function automatic logic [2:0] bank_block(input logic [2:0] cfg, input logic [1:0] qtr);
        logic [2:0] blk;
        blk = {1'b0, qtr};
        unique case (cfg)
            3'd0: blk = {1'b0, qtr};
            3'd1: blk = (qtr == 2'd3) ? 3'd7 : {1'b0, qtr};
            3'd2: blk = {1'b1, qtr};
            3'd3: begin
                unique case (qtr)
                    2'd0:    blk = 3'd0;
                    2'd1:    blk = 3'd3;
                    2'd2:    blk = 3'd2;
                    default: blk = 3'd7;
                endcase
            end
            // Tables 4 to 7 swap their own block into the second quarter
            default: blk = (qtr == 2'd1) ? cfg : {1'b0, qtr};
        endcase
        return blk;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gate_array_port_and_bank_map_top.sv =====
// Top level of the gate-array port decoder and memory bank mapper.
// Depends on gapbm_pkg for the word layout, codes and bank table.
// Single module: decode, state update and result register with a skid stage.
`default_nettype none

// One word in, one word out. Each input word is either a port write or a CPU
// memory read/write, selected by s_tuser. Port writes update the pen select,
// border colour, screen mode, ROM visibility and RAM bank table in the cycle
// they are accepted, so the very next word already sees the new mapping.
// Memory words are mapped to the lower ROM, the upper ROM or one of eight
// physical 16K RAM blocks plus a 14-bit offset. Every word yields exactly one
// result word, which also reports the current screen mode and border colour.
// Throughput is one word per clock while the output is not stalled; each
// result is registered. The limit is the single decode stage feeding the
// result register; a one-deep skid register keeps s_tready high while one
// finished word waits on m_tready. Palette colour writes are decoded but the
// palette is not exported, so only the border part of a colour write is kept.
module gate_array_port_and_bank_map_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] port, [23:16] data, [39:24] address
    input  wire logic [39:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] to_rom, [1] rom_choice, [4:2] ram_block, [18:5] offset,
    // [19] write_enable, [27:20] write_data, [29:28] screen_mode,
    // [34:30] border_color, [39:35] zero
    output logic [39:0]      m_tdata
);

    logic [1:0]  kind;
    logic [15:0] port;
    logic [7:0]  data;
    logic [15:0] address;
    logic [1:0]  func;
    logic [1:0]  qtr;
    logic        accept;
    logic        ga_sel;

    // Mapper state
    logic [gapbm_pkg::PEN_W-1:0] pen_sel_reg,   pen_sel_next;
    logic [4:0]                  border_reg,    border_next;
    logic [1:0]                  mode_reg,      mode_next;
    logic [2:0]                  bank_cfg_reg,  bank_cfg_next;
    logic                        lrom_on_reg,   lrom_on_next;
    logic                        urom_on_reg,   urom_on_next;

    // Output register and skid stage
    gapbm_pkg::result_t res_new;
    gapbm_pkg::result_t out_reg;
    gapbm_pkg::result_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    assign port    = s_tdata[15:0];
    assign data    = s_tdata[23:16];
    assign address = s_tdata[39:24];
    assign kind    = s_tuser;
    assign func    = data[7:6];
    assign qtr     = address[15:14];
    assign ga_sel  = !port[15] && port[14];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Port decode: next state for an accepted port write
    always_comb begin
        pen_sel_next  = pen_sel_reg;
        border_next   = border_reg;
        mode_next     = mode_reg;
        bank_cfg_next = bank_cfg_reg;
        lrom_on_next  = lrom_on_reg;
        urom_on_next  = urom_on_reg;
        if (kind == gapbm_pkg::KIND_PORT_WR) begin
            if (ga_sel) begin
                unique case (func)
                    gapbm_pkg::FUNC_PEN_SEL: pen_sel_next = data[4:0];
                    gapbm_pkg::FUNC_PEN_COL: begin
                        // Selections past the palette address the border
                        if (pen_sel_reg >= gapbm_pkg::PEN_W'(gapbm_pkg::PEN_COUNT)) begin
                            border_next = data[4:0];
                        end
                    end
                    gapbm_pkg::FUNC_MODE_ROM: begin
                        mode_next    = data[1:0];
                        lrom_on_next = !data[2];
                        urom_on_next = !data[3];
                    end
                    default: ;
                endcase
            end
            if (!port[15] && func == gapbm_pkg::FUNC_RAM_CFG) begin
                bank_cfg_next = data[2:0];
            end
        end
    end

    // Memory map: result word for this input word
    always_comb begin
        res_new              = '0;
        res_new.screen_mode  = mode_next;
        res_new.border_color = border_next;
        if (kind == gapbm_pkg::KIND_MEM_RD || kind == gapbm_pkg::KIND_MEM_WR) begin
            res_new.offset = address[13:0];
            if (kind == gapbm_pkg::KIND_MEM_RD && qtr == gapbm_pkg::QTR_LOWER && lrom_on_reg) begin
                res_new.to_rom = 1'b1;
            end else if (kind == gapbm_pkg::KIND_MEM_RD && qtr == gapbm_pkg::QTR_UPPER
                         && urom_on_reg) begin
                res_new.to_rom     = 1'b1;
                res_new.rom_choice = 1'b1;
            end else begin
                res_new.ram_block = gapbm_pkg::bank_block(bank_cfg_reg, qtr);
            end
            if (kind == gapbm_pkg::KIND_MEM_WR) begin
                res_new.write_enable = 1'b1;
                res_new.write_data   = data;
            end
        end
    end

    // Advance state on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_sel_reg  <= '0;
            border_reg   <= '0;
            mode_reg     <= 2'd1;
            bank_cfg_reg <= '0;
            lrom_on_reg  <= 1'b1;
            urom_on_reg  <= 1'b0;
        end else if (accept) begin
            pen_sel_reg  <= pen_sel_next;
            border_reg   <= border_next;
            mode_reg     <= mode_next;
            bank_cfg_reg <= bank_cfg_next;
            lrom_on_reg  <= lrom_on_next;
            urom_on_reg  <= urom_on_next;
        end
    end

    // Output register with skid: drain skid first, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res_new;
            end
        end else if (accept) begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - gapbm_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

`default_nettype wire
